// File: sv/cmeg_pkg.sv
// shared types and constants for the copying model edge generator
// no dependencies; used by cmeg_ctrl and copying_model_edge_generator
`default_nettype none

package cmeg_pkg;

    localparam int MAX_VERTICES_DEF = 4096;
    localparam int MAX_DEGREE_DEF   = 16;

    localparam int VTX_W      = 12;
    localparam int SLOT_W     = 4;
    localparam int DEG_REG_W  = 5;
    localparam int INIT_REG_W = 13;
    localparam int ADD_REG_W  = 12;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [DEG_REG_W-1:0]  OUT_DEGREE_RST = DEG_REG_W'(4);
    localparam logic [INIT_REG_W-1:0] INITIAL_RST    = INIT_REG_W'(16);
    localparam logic [ADD_REG_W-1:0]  ADDED_RST      = '0;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_PICK = 2'd1,
        ST_FINISHED = 2'd2,
        ST_BAD_LOAD = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUT_DEGREE = 2'd0,
        CFG_INITIAL    = 2'd1,
        CFG_ADDED      = 2'd2
    } t_cfg_idx;

    // decoded item handed from the control unit to the write-back stage
    typedef struct packed {
        logic             we;
        logic             copy;
        logic             edge_valid;
        t_status          status;
        logic [VTX_W-1:0] src;
        logic [VTX_W-1:0] val;
    } t_item;

endpackage

`default_nettype wire

// File: sv/copying_model_edge_generator.sv
// Copying model edge generator. Takes one item per cycle with no gaps as long as
// results are taken; a stalled result holds the item behind it and stalls the input.
// An item is decoded as it is taken, while its adjacency memory read is issued,
// then moves to write-back, where its target is written to the memory and
// placed in the output register; the single adjacency memory (one read port, one
// write port, registered read) sets this two-stage depth. A read of the entry that
// the item ahead is writing in the same cycle is forwarded. There is no clearing
// pass after reset: items are taken from the first cycle after reset.
// top level; depends on cmeg_pkg, cmeg_ctrl and cmeg_ram
`default_nettype none

module copying_model_edge_generator #(
    parameter int MAX_VERTICES = cmeg_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = cmeg_pkg::MAX_DEGREE_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cmeg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [cmeg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_mode,
    input  wire logic [cmeg_pkg::VTX_W-1:0]      i_vertex,
    input  wire logic [cmeg_pkg::SLOT_W-1:0]     i_slot,
    input  wire logic [cmeg_pkg::VTX_W-1:0]      i_neighbour,
    input  wire logic                            i_coin_uniform,
    input  wire logic [cmeg_pkg::VTX_W-1:0]      i_pick,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [cmeg_pkg::VTX_W-1:0]           o_edge_source,
    output logic [cmeg_pkg::VTX_W-1:0]           o_edge_target,
    output logic                                 o_edge_valid,
    output logic [1:0]                           o_status
);

    import cmeg_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int SW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int AW = VW + SW;

    t_item            item;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic [VTX_W-1:0] ram_q;
    logic [VTX_W-1:0] mem_val;
    logic [VTX_W-1:0] s1_val;
    logic             accept;
    logic             out_load;
    logic             s1_adv;
    logic             ram_we;

    logic             r_s1_vld;
    t_item            r_s1;
    logic [AW-1:0]    r_s1_waddr;
    logic             r_fwd;
    logic [VTX_W-1:0] r_fwd_data;

    logic             r_out_vld;
    logic [VTX_W-1:0] r_src;
    logic [VTX_W-1:0] r_tgt;
    logic             r_ev;
    t_status          r_status;

    assign out_load   = !r_out_vld || !i_out_stall;
    assign s1_adv     = r_s1_vld && out_load;
    assign o_in_stall = r_s1_vld && !out_load;
    assign accept     = i_in_valid && !o_in_stall;

    // same-entry write in flight forwards over the stale read
    assign mem_val = r_fwd ? r_fwd_data : ram_q;
    assign s1_val  = r_s1.copy ? mem_val : r_s1.val;
    assign ram_we  = s1_adv && r_s1.we;

    cmeg_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE),
        .AW           (AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_mode         (i_mode),
        .i_vertex       (i_vertex),
        .i_slot         (i_slot),
        .i_neighbour    (i_neighbour),
        .i_coin_uniform (i_coin_uniform),
        .i_pick         (i_pick),
        .o_item         (item),
        .o_waddr        (waddr),
        .o_raddr        (raddr)
    );

    cmeg_ram #(
        .WIDTH (VTX_W),
        .DEPTH (1 << AW)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_waddr),
        .i_wdata (s1_val),
        .i_re    (accept),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1       <= item;
            r_s1_waddr <= waddr;
            r_fwd      <= ram_we && (r_s1_waddr == raddr);
            r_fwd_data <= s1_val;
        end
        if (s1_adv) begin
            r_src    <= r_s1.src;
            r_tgt    <= r_s1.edge_valid ? s1_val : '0;
            r_ev     <= r_s1.edge_valid;
            r_status <= r_s1.status;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_edge_source = r_src;
    assign o_edge_target = r_tgt;
    assign o_edge_valid  = r_ev;
    assign o_status      = r_status;

endmodule

`default_nettype wire

// File: sv/cmeg_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module cmeg_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/cmeg_ctrl.sv
// configuration registers, vertex and slot counters, item decode
// depends on cmeg_pkg
`default_nettype none

module cmeg_ctrl #(
    parameter int MAX_VERTICES = 4096,
    parameter int MAX_DEGREE   = 16,
    parameter int AW           = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cmeg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [cmeg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_accept,
    input  wire logic                            i_mode,
    input  wire logic [cmeg_pkg::VTX_W-1:0]      i_vertex,
    input  wire logic [cmeg_pkg::SLOT_W-1:0]     i_slot,
    input  wire logic [cmeg_pkg::VTX_W-1:0]      i_neighbour,
    input  wire logic                            i_coin_uniform,
    input  wire logic [cmeg_pkg::VTX_W-1:0]      i_pick,
    output cmeg_pkg::t_item                      o_item,
    output logic [AW-1:0]                        o_waddr,
    output logic [AW-1:0]                        o_raddr
);

    import cmeg_pkg::*;

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int SW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DW  = $clog2(MAX_DEGREE + 1);
    localparam int EW  = (DW > DEG_REG_W) ? DW : DEG_REG_W;
    localparam int CW  = (DW > SLOT_W) ? DW : SLOT_W;
    localparam int VCW = ($clog2(MAX_VERTICES + 1) > INIT_REG_W) ?
                         $clog2(MAX_VERTICES + 1) : INIT_REG_W;
    localparam int LW  = (VCW > INIT_REG_W + 1) ? VCW : INIT_REG_W + 1;

    logic [DEG_REG_W-1:0]  r_od,  n_od;
    logic [INIT_REG_W-1:0] r_init, n_init;
    logic [ADD_REG_W-1:0]  r_add, n_add;
    logic [VCW-1:0]        r_cnv, n_cnv;
    logic [SW-1:0]         r_sc,  n_sc;

    logic [VCW-1:0] it_cnv;
    logic [SW-1:0]  it_sc;
    logic [EW-1:0]  od_x;
    logic [DW-1:0]  deg;
    logic [CW-1:0]  deg_c;
    logic [CW-1:0]  cs1_c;
    logic [LW-1:0]  init_eff;
    logic [LW-1:0]  sum;
    logic [LW-1:0]  limit;
    logic [LW-1:0]  cv_x;
    logic [VCW-1:0] cv;
    logic [SW-1:0]  cs;
    logic           wrap;
    logic           bad_load;

    // effective degree and vertex bounds
    always_comb begin
        od_x = EW'(r_od);
        if (od_x == '0) begin
            deg = DW'(1);
        end else if (od_x > EW'(MAX_DEGREE)) begin
            deg = DW'(MAX_DEGREE);
        end else begin
            deg = DW'(od_x);
        end
        deg_c    = CW'(deg);
        init_eff = (LW'(r_init) > LW'(MAX_VERTICES)) ? LW'(MAX_VERTICES) : LW'(r_init);
        sum      = LW'(r_init) + LW'(r_add);
        limit    = (sum > LW'(MAX_VERTICES)) ? LW'(MAX_VERTICES) : sum;
        wrap     = CW'(r_sc) >= deg_c;
        cv       = wrap ? r_cnv + VCW'(1) : r_cnv;
        cv_x     = LW'(cv);
        cs       = wrap ? '0 : r_sc;
        cs1_c    = CW'(cs) + CW'(1);
        bad_load = (LW'(i_vertex) >= init_eff) || (CW'(i_slot) >= deg_c) ||
                   (LW'(i_neighbour) >= init_eff);
    end

    // item decode
    always_comb begin
        o_item            = '0;
        o_item.status     = ST_OK;
        o_waddr           = {VW'(i_vertex), SW'(i_slot)};
        o_raddr           = {VW'(i_pick), cs};
        it_cnv            = r_cnv;
        it_sc             = r_sc;
        if (!i_mode) begin
            if (bad_load) begin
                o_item.status = ST_BAD_LOAD;
            end else begin
                o_item.we  = 1'b1;
                o_item.val = i_neighbour;
                if (i_neighbour > i_vertex) begin
                    o_item.edge_valid = 1'b1;
                    o_item.src        = i_vertex;
                end
            end
        end else if (LW'(r_cnv) >= limit) begin
            o_item.status = ST_FINISHED;
        end else begin
            it_cnv = cv;
            it_sc  = cs;
            if (cv_x >= limit) begin
                o_item.status = ST_FINISHED;
            end else if (LW'(i_pick) >= cv_x) begin
                o_item.status = ST_BAD_PICK;
            end else begin
                o_item.we         = 1'b1;
                o_item.copy       = !i_coin_uniform;
                o_item.edge_valid = 1'b1;
                o_item.src        = VTX_W'(cv);
                o_item.val        = i_pick;
                o_waddr           = {VW'(cv), cs};
                if (cs1_c >= deg_c) begin
                    it_sc  = '0;
                    it_cnv = cv + VCW'(1);
                end else begin
                    it_sc  = SW'(cs1_c);
                end
            end
        end
    end

    always_comb begin
        n_od   = r_od;
        n_init = r_init;
        n_add  = r_add;
        n_cnv  = r_cnv;
        n_sc   = r_sc;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OUT_DEGREE: begin
                    n_od = i_cfg_data[DEG_REG_W-1:0];
                end
                CFG_INITIAL: begin
                    n_init = i_cfg_data[INIT_REG_W-1:0];
                    n_cnv  = VCW'(i_cfg_data[INIT_REG_W-1:0]);
                    n_sc   = '0;
                end
                CFG_ADDED: begin
                    n_add = i_cfg_data[ADD_REG_W-1:0];
                end
                default: begin
                    n_od = r_od;
                end
            endcase
        end else if (i_accept) begin
            n_cnv = it_cnv;
            n_sc  = it_sc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_od   <= OUT_DEGREE_RST;
            r_init <= INITIAL_RST;
            r_add  <= ADDED_RST;
            r_cnv  <= VCW'(INITIAL_RST);
            r_sc   <= '0;
        end else begin
            r_od   <= n_od;
            r_init <= n_init;
            r_add  <= n_add;
            r_cnv  <= n_cnv;
            r_sc   <= n_sc;
        end
    end

endmodule

`default_nettype wire
